>>> rtl/lbc_pkg.sv
// Package for the LZW byte compressor: sizes, hash, controller states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package lbc_pkg;
	localparam int DICT_ENTRIES = 4096;
	localparam int BYTE_W       = 8;
	localparam int CODE_W       = $clog2(DICT_ENTRIES);
	localparam int NFC_W        = CODE_W + 1;
	localparam int KEY_W        = CODE_W + BYTE_W;
	localparam int TBL_AW       = CODE_W + 1;
	localparam int EPOCH_W      = 8;
	localparam int FIRST_ENTRY  = 256;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_MISS,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [CODE_W-1:0]  code;
		logic [EPOCH_W-1:0] epoch;
	} slot_t;

	typedef struct packed {
		logic load;
		logic take_hit;
		logic probe_next;
		logic emit_miss;
		logic emit_fin;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic live;
		logic match;
		logic fin;
		logic wrap;
		logic clr_last;
		logic out_free;
	} sts_t;

	function automatic logic [TBL_AW-1:0] slot_hash(input logic [CODE_W-1:0] prefix,
			input logic [BYTE_W-1:0] b);
		logic [TBL_AW-1:0] p;
		logic [TBL_AW-1:0] s;
		p = TBL_AW'(prefix);
		s = TBL_AW'(b) << (TBL_AW - BYTE_W);
		return p ^ s;
	endfunction
endpackage
`default_nettype wire

>>> rtl/lbc_ctrl.sv
// Controller FSM for the LZW byte compressor.
// Depends on lbc_pkg (state_t, cmd_t, sts_t).
`default_nettype none
module lbc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          is_final,
	input  wire lbc_pkg::sts_t sts,
	output lbc_pkg::cmd_t      cmd,
	output logic               in_ready
);
	lbc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbc_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = lbc_pkg::ST_IDLE;
			end
			lbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!sts.first) state_d = lbc_pkg::ST_READ;
					else if (is_final) state_d = lbc_pkg::ST_FIN;
				end
			end
			lbc_pkg::ST_READ: state_d = lbc_pkg::ST_CMP;
			lbc_pkg::ST_CMP: begin
				if (!sts.live) state_d = lbc_pkg::ST_MISS;
				else if (!sts.match) state_d = lbc_pkg::ST_READ;
				else state_d = sts.fin ? lbc_pkg::ST_FIN : lbc_pkg::ST_IDLE;
			end
			lbc_pkg::ST_MISS: begin
				if (sts.out_free) state_d = sts.fin ? lbc_pkg::ST_FIN : lbc_pkg::ST_IDLE;
			end
			lbc_pkg::ST_FIN: begin
				if (sts.out_free) state_d = sts.wrap ? lbc_pkg::ST_CLEAR : lbc_pkg::ST_IDLE;
			end
			default: state_d = lbc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == lbc_pkg::ST_IDLE);
		cmd.load       = (state_q == lbc_pkg::ST_IDLE) && in_valid;
		cmd.take_hit   = (state_q == lbc_pkg::ST_CMP) && sts.live && sts.match;
		cmd.probe_next = (state_q == lbc_pkg::ST_CMP) && sts.live && !sts.match;
		cmd.emit_miss  = (state_q == lbc_pkg::ST_MISS) && sts.out_free;
		cmd.emit_fin   = (state_q == lbc_pkg::ST_FIN) && sts.out_free;
		cmd.clr_step   = (state_q == lbc_pkg::ST_CLEAR);
	end
endmodule
`default_nettype wire

>>> rtl/lbc_dpath.sv
// Datapath for the LZW byte compressor: hashed dictionary RAM with epoch
// tags, code registers and output register. Depends on lbc_pkg.
`default_nettype none
module lbc_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lbc_pkg::cmd_t               cmd,
	output lbc_pkg::sts_t                    sts,
	input  wire logic [lbc_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                        is_final,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [lbc_pkg::CODE_W-1:0]       out_code,
	output logic                             end_of_stream
);
	localparam int TblDepth = 2 ** lbc_pkg::TBL_AW;

	lbc_pkg::slot_t mem [TblDepth];
	lbc_pkg::slot_t rd_q;
	lbc_pkg::slot_t wd;
	logic           we;

	logic [lbc_pkg::TBL_AW-1:0]  addr_q;
	logic [lbc_pkg::BYTE_W-1:0]  byte_q;
	logic                        fin_q;
	logic                        started_q;
	logic [lbc_pkg::CODE_W-1:0]  cur_q;
	logic [lbc_pkg::NFC_W-1:0]   nfc_q;
	logic [lbc_pkg::EPOCH_W-1:0] epoch_q;
	logic                        ov_q;
	logic [lbc_pkg::CODE_W-1:0]  code_q;
	logic                        eos_q;
	logic                        room;

	assign room = (nfc_q != lbc_pkg::NFC_W'(lbc_pkg::DICT_ENTRIES));

	always_comb begin
		we = cmd.clr_step || (cmd.emit_miss && room);
		wd.key   = {cur_q, byte_q};
		wd.code  = nfc_q[lbc_pkg::CODE_W-1:0];
		wd.epoch = cmd.clr_step ? '0 : epoch_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr_q] <= wd;
		rd_q <= mem[addr_q];
	end

	always_comb begin
		sts.first    = !started_q;
		sts.live     = (rd_q.epoch == epoch_q);
		sts.match    = (rd_q.key == {cur_q, byte_q});
		sts.fin      = fin_q;
		sts.wrap     = (epoch_q == '1);
		sts.clr_last = (addr_q == '1);
		sts.out_free = !ov_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			started_q <= 1'b0;
			cur_q     <= '0;
			nfc_q     <= lbc_pkg::NFC_W'(lbc_pkg::FIRST_ENTRY);
			epoch_q   <= lbc_pkg::EPOCH_W'(1);
			ov_q      <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			if (cmd.emit_miss || cmd.emit_fin) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (cmd.load) begin
				fin_q <= is_final;
				if (!started_q) begin
					cur_q     <= lbc_pkg::CODE_W'(data_byte);
					started_q <= 1'b1;
				end else begin
					addr_q <= lbc_pkg::slot_hash(cur_q, data_byte);
				end
			end
			if (cmd.take_hit) cur_q <= rd_q.code;
			if (cmd.probe_next || cmd.clr_step) addr_q <= addr_q + 1'b1;
			if (cmd.emit_miss) begin
				cur_q <= lbc_pkg::CODE_W'(byte_q);
				if (room) nfc_q <= nfc_q + 1'b1;
			end
			if (cmd.emit_fin) begin
				cur_q     <= '0;
				started_q <= 1'b0;
				nfc_q     <= lbc_pkg::NFC_W'(lbc_pkg::FIRST_ENTRY);
				if (epoch_q == '1) begin
					epoch_q <= lbc_pkg::EPOCH_W'(1);
					addr_q  <= '0;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) byte_q <= data_byte;
		if (cmd.emit_miss || cmd.emit_fin) begin
			code_q <= cur_q;
			eos_q  <= cmd.emit_fin;
		end
	end

	assign out_valid     = ov_q;
	assign out_code      = code_q;
	assign end_of_stream = eos_q;
endmodule
`default_nettype wire

>>> rtl/lzw_byte_compressor_top.sv
// Top level of the 12-bit LZW byte compressor.
// Depends on lbc_pkg, lbc_ctrl and lbc_dpath.
//
// Input channel (in_valid/in_ready): one request per byte, data_byte plus
// is_final marking the last byte of a stream. Output channel
// (out_valid/out_ready): out_code with end_of_stream set on a stream's last
// code. A byte yields zero, one or two codes.
// The dictionary is a hash table of 2*4096 slots in one single-port RAM,
// linear probing, each probe a read state followed by a compare state.
// A byte that opens a stream needs no probe, else it takes one or more
// probes; each emitted code takes an emit step. Stored codes become stale
// by an epoch tag. After reset, and after every 255th stream end, a
// clearing pass writes all 8192 slots, one per cycle, with in_ready low.
// Results sit in one output register; while it is full and out_ready is
// low, the block stalls only when it must emit the next code.
`default_nettype none
module lzw_byte_compressor_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_final,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [11:0]      out_code,
	output logic             end_of_stream
);
	lbc_pkg::cmd_t cmd;
	lbc_pkg::sts_t sts;

	lbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_final (is_final),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	lbc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.data_byte     (data_byte),
		.is_final      (is_final),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_code      (out_code),
		.end_of_stream (end_of_stream)
	);
endmodule
`default_nettype wire

>>> rtl/lbc_checker.sv
// Port-level checks for the LZW byte compressor, bound to the top level.
// Depends on lzw_byte_compressor_top.
`default_nettype none
module lbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        is_final,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [11:0] out_code,
	input wire logic        end_of_stream
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before accept");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_code) && $stable(end_of_stream))
		else $error("output payload changed while stalled");

	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_final |=> !in_ready)
		else $error("ready right after final request");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("code emitted while idle");
endmodule

bind lzw_byte_compressor_top lbc_checker u_lbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.is_final      (is_final),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_code      (out_code),
	.end_of_stream (end_of_stream)
);
`default_nettype wire

>>> sim/tb_lzw_byte_compressor_top.sv
// Testbench for lzw_byte_compressor_top: byte streams in, LZW codes checked
// against a behavioral dictionary model kept inside the bench.
// Depends on lbc_pkg and the compressor RTL.
`default_nettype none
module tb_lzw_byte_compressor_top;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [lbc_pkg::CODE_W-1:0] code;
		logic                       eos;
	} code_exp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        data_byte = 8'd0;
	logic              is_final = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [11:0]       out_code;
	logic              end_of_stream;

	code_exp_t                  code_q[$];
	int                         dict[int];
	logic [lbc_pkg::NFC_W-1:0]  free_code;
	logic [lbc_pkg::CODE_W-1:0] cur_code;
	logic                       in_stream;
	int                         errors = 0;
	int                         cycles = 0;
	bit                         send_idle = 1'b1;
	bit                         recv_idle = 1'b1;
	int                         hold_left = 0;

	lzw_byte_compressor_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .is_final(is_final),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_code(out_code), .end_of_stream(end_of_stream)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL lzw_byte_compressor_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (recv_idle && $urandom_range(99) < 28) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report(input string msg);
		$display("mismatch @%0d: %s", cycles, msg);
		errors++;
	endtask

	always @(negedge clk) begin
		code_exp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (code_q.size() == 0) begin
				report($sformatf("unexpected code %0d eos %0b", out_code, end_of_stream));
			end else begin
				e = code_q.pop_front();
				if (out_code !== e.code)
					report($sformatf("code got %0d want %0d", out_code, e.code));
				if (end_of_stream !== e.eos)
					report($sformatf("eos got %0b want %0b", end_of_stream, e.eos));
			end
		end
	end

	function automatic void clear_dict();
		dict.delete();
		free_code = lbc_pkg::NFC_W'(lbc_pkg::FIRST_ENTRY);
		cur_code = '0;
		in_stream = 1'b0;
	endfunction

	function automatic void push_code(input logic [lbc_pkg::CODE_W-1:0] c, input logic eos);
		code_exp_t e;
		e.code = c;
		e.eos = eos;
		code_q.push_back(e);
	endfunction

	function automatic void compress_byte(input logic [7:0] b, input logic fin);
		int key;
		if (!in_stream) begin
			cur_code = lbc_pkg::CODE_W'(b);
			in_stream = 1'b1;
		end else begin
			key = int'({cur_code, b});
			if (dict.exists(key)) begin
				cur_code = lbc_pkg::CODE_W'(dict[key]);
			end else begin
				push_code(cur_code, 1'b0);
				if (free_code < lbc_pkg::NFC_W'(lbc_pkg::DICT_ENTRIES)) begin
					dict[key] = int'(free_code);
					free_code++;
				end
				cur_code = lbc_pkg::CODE_W'(b);
			end
		end
		if (fin) begin
			push_code(cur_code, 1'b1);
			clear_dict();
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		bit acc;
		if (send_idle && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			while ($urandom_range(99) < 28) @(posedge clk);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_final <= fin;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
		compress_byte(b, fin);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (code_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_stream(input int len, input int alpha);
		int i;
		for (i = 0; i < len; i++)
			send_byte(alpha >= 256 ? 8'($urandom) : 8'($urandom_range(alpha - 1)),
				i == len - 1);
	endtask

	task automatic test_directed();
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		repeat (6) send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h7f, 1'b1);
		wait_drain();
	endtask

	// one long stream, so the dictionary grows to several hundred entries, then a short one
	task automatic test_long_stream();
		send_stream(600, 256);
		send_stream(30, 4);
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		send_stream(60, 256);
		send_stream(40, 3);
		wait_drain();
	endtask

	task automatic test_random();
		int n;
		int len;
		int sel;
		n = 0;
		while (n < 240) begin
			if (n >= 80 && n < 180) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end else begin
				send_idle = 1'b1;
				recv_idle = 1'b1;
			end
			len = $urandom_range(1, 60);
			sel = $urandom_range(9);
			if (sel == 0) begin
				// a stray single-byte stream
				send_byte(8'($urandom), 1'b1);
				len = 1;
			end else if (sel < 4) begin
				send_stream(len, 256);
			end else begin
				send_stream(len, $urandom_range(2, 8));
			end
			n += len;
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
		wait_drain();
	endtask

	initial begin
		clear_dict();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		test_long_stream();
		repeat (100) @(posedge clk);
		if (errors == 0 && code_q.size() == 0) begin
			$display("PASS lzw_byte_compressor_top");
		end else begin
			$display("FAIL lzw_byte_compressor_top");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
rtl/lbc_pkg.sv
rtl/lbc_ctrl.sv
rtl/lbc_dpath.sv
rtl/lzw_byte_compressor_top.sv
rtl/lbc_checker.sv
sim/tb_lzw_byte_compressor_top.sv
